FILE: hdl/reliable_send_window_macros.svh
// Assertion macros shared by the reliable_send_window checker.
// No dependencies; included by bare file name.
`ifndef RELIABLE_SEND_WINDOW_MACROS_SVH
`define RELIABLE_SEND_WINDOW_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("reliable_send_window assertion failed");

// Next-cycle implication, disabled during reset.
`define RSW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("reliable_send_window assertion failed");

`endif

FILE: hdl/rsw_pkg.sv
// Shared types and codes of the reliable send window.
// No dependencies; used by rsw_cell, reliable_send_window and rsw_checker through rsw_pkg:: names.
package rsw_pkg;

    typedef struct packed {
        logic [15:0] handle;
        logic [1:0]  status;
        logic [15:0] timer;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [15:0] number;
    } event_t;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_SENT    = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_ACK    = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] EV_TX      = 2'd0;
    localparam logic [1:0] EV_RETX    = 2'd1;
    localparam logic [1:0] EV_UNKNOWN = 2'd2;
    localparam logic [1:0] EV_FULL    = 2'd3;

    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam int          NCNT_W        = 6;
    localparam logic [5:0]  MAX_OUT       = 6'd32;
    localparam logic [5:0]  WINDOW_RESET  = 6'd10;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

endpackage

FILE: hdl/rsw_cell.sv
// One queue cell of the send window ring: holds one entry, hands it on.
// Depends on rsw_pkg.
module rsw_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  rsw_pkg::entry_t d_in,
    output rsw_pkg::entry_t q
);

    rsw_pkg::entry_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.status <= rsw_pkg::ST_PENDING;
            q_reg.timer  <= '0;
        end else if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

FILE: hdl/reliable_send_window.sv
// Top level of the reliable send window (selective-repeat sender).
// Depends on rsw_pkg and rsw_cell.
//
// Usage:
//   Input channel s_*: one transaction per command. s_tuser carries the action
//   (submit, ack, tick, clear); s_tdata carries handle, ack number, ack flag
//   and elapsed milliseconds. s_tready is high only while the block is idle.
//   Result channel m_*: zero or more transactions per command, m_tlast on the
//   final one. m_tuser is the event kind, m_tdata the handle and number.
//   Configuration: cfg_we writes window_size (index 0) or timeout_ms (index 1);
//   the user writes them only while idle; the block itself does not enforce this.
// Operation:
//   The queue lives in a ring of QUEUE_DEPTH cells that rotates one place per
//   cycle past a single processing stage while a pass runs and the output does
//   not hold it back. Clear, queue-full and unknown-ack commands skip the ring;
//   submit, tick and failed acks take one full rotation; a successful ack that
//   retires one or more entries from the head takes a second rotation.
// Reset: the queue is emptied, base number zero, registers at 10 and 3000 ms.
// Stall: results pass through a holding stage and an output register; when
//   m_tready stays low the ring freezes once both are full; no result is dropped.
module reliable_send_window #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SEQ_MODULUS = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // msg_handle, ack_number, ack_ok, elapsed_ms
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_handle, tx_number
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int PW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = $clog2(2 * QUEUE_DEPTH);
    localparam int CW = ((KW > 6) ? KW : 6) + 1;
    localparam logic [16:0] SEQ_MOD17 = 17'(SEQ_MODULUS);
    localparam logic [15:0] SEQ_LAST  = 16'(SEQ_MODULUS - 1);
    localparam logic [KW-1:0] K_LAST  = KW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_PASS1  = 3'd2;
    localparam logic [2:0] S_MID    = 3'd3;
    localparam logic [2:0] S_PASS2  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]  state_reg, state_next;
    logic [5:0]  window_reg, window_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [1:0]  act_reg, act_next;
    logic [15:0] hin_reg, hin_next;
    logic [15:0] ackn_reg, ackn_next;
    logic        ackok_reg, ackok_next;
    logic [15:0] elap_reg, elap_next;
    logic [PW-1:0] count_reg, count_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] num_reg, num_next;
    logic [KW-1:0] k_reg, k_next;
    logic [PW-1:0] r_reg, r_next;
    logic [PW-1:0] d_reg, d_next;
    logic        lead_reg, lead_next;
    logic [rsw_pkg::NCNT_W-1:0] n_reg, n_next;
    logic        hold_v_reg, hold_v_next;
    rsw_pkg::event_t hold_reg, hold_next;
    logic        mv_reg, mv_next;
    rsw_pkg::event_t mev_reg, mev_next;
    logic        mlast_reg, mlast_next;

    // ------------------------------------------------------------------
    // Cell ring: cell 0 feeds the processing stage, which feeds the last
    // cell, so one rotation visits every queue position in order.
    // ------------------------------------------------------------------
    rsw_pkg::entry_t cell_q [QUEUE_DEPTH];
    rsw_pkg::entry_t proc_out;
    logic            step_en;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        rsw_pkg::entry_t din;
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign din = proc_out;
        end else begin : g_mid
            assign din = cell_q[i+1];
        end
        rsw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (step_en),
            .d_in     (din),
            .q        (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !mv_reg || m_tready;
    assign step_en  = ((state_reg == S_PASS1) || (state_reg == S_PASS2)) &&
                      (!hold_v_reg || out_free);
    assign s_tready = (state_reg == S_IDLE);

    // Ack lookup: the nearest-head match sits at (ack - base) mod modulus.
    logic [16:0] diff17;
    logic        ack_found;
    always_comb begin
        if (ackn_reg >= base_reg) begin
            diff17 = {1'b0, ackn_reg} - {1'b0, base_reg};
        end else begin
            diff17 = {1'b0, ackn_reg} + SEQ_MOD17 - {1'b0, base_reg};
        end
        ack_found = ({1'b0, ackn_reg} < SEQ_MOD17) && (diff17 < 17'(count_reg));
    end

    // ------------------------------------------------------------------
    // Processing stage on the entry leaving cell 0
    // ------------------------------------------------------------------
    rsw_pkg::entry_t cur;
    logic [CW-1:0]   kc, cnt_c, win_c, d_c, r_c, newpos;
    logic [16:0]     tsum;
    logic [15:0]     tsat;
    logic [1:0]      st_new;
    logic            ev_valid, r_inc, lead_clr, base_inc;
    rsw_pkg::event_t ev;

    assign cur    = cell_q[0];
    assign kc     = CW'(k_reg);
    assign cnt_c  = CW'(count_reg);
    assign win_c  = CW'(window_reg);
    assign d_c    = CW'(d_reg);
    assign r_c    = CW'(r_reg);
    assign newpos = kc - r_c;
    assign tsum   = {1'b0, cur.timer} + {1'b0, elap_reg};
    assign tsat   = tsum[16] ? 16'hFFFF : tsum[15:0];
    assign st_new = (kc == d_c) ? rsw_pkg::ST_DONE : cur.status;

    always_comb begin
        proc_out  = cur;
        ev_valid  = 1'b0;
        ev.kind   = rsw_pkg::EV_TX;
        ev.handle = cur.handle;
        ev.number = num_reg;
        r_inc     = 1'b0;
        lead_clr  = 1'b0;
        base_inc  = 1'b0;
        if (state_reg == S_PASS1) begin
            unique case (act_reg)
                rsw_pkg::ACT_SUBMIT: begin
                    if (kc == cnt_c) begin
                        proc_out.handle = hin_reg;
                        proc_out.timer  = '0;
                        if (cnt_c + CW'(1) <= win_c) begin
                            proc_out.status = rsw_pkg::ST_SENT;
                            ev_valid        = 1'b1;
                            ev.handle       = hin_reg;
                        end else begin
                            proc_out.status = rsw_pkg::ST_PENDING;
                        end
                    end
                end
                rsw_pkg::ACT_ACK: begin
                    if (ackok_reg) begin
                        // mark done, count the done run at the head
                        proc_out.status = st_new;
                        if (lead_reg && kc < cnt_c && st_new == rsw_pkg::ST_DONE) begin
                            r_inc = 1'b1;
                        end else begin
                            lead_clr = 1'b1;
                        end
                    end else if (kc == d_c) begin
                        proc_out.timer = '0;
                        ev_valid       = 1'b1;
                        ev.kind        = rsw_pkg::EV_RETX;
                    end
                end
                rsw_pkg::ACT_TICK: begin
                    if (kc < cnt_c && cur.status == rsw_pkg::ST_SENT) begin
                        if (tsat > timeout_reg && n_reg < rsw_pkg::MAX_OUT) begin
                            proc_out.timer = '0;
                            ev_valid       = 1'b1;
                            ev.kind        = rsw_pkg::EV_RETX;
                        end else begin
                            proc_out.timer = tsat;
                        end
                    end
                end
                default: ;
            endcase
        end else if (state_reg == S_PASS2) begin
            // retired positions pass through; pending survivors inside the window go out
            if (kc < r_c) begin
                base_inc = 1'b1;
            end else if (kc < DEPTH_C && newpos < cnt_c && newpos < win_c &&
                         cur.status == rsw_pkg::ST_PENDING &&
                         n_reg < rsw_pkg::MAX_OUT) begin
                proc_out.status = rsw_pkg::ST_SENT;
                proc_out.timer  = '0;
                ev_valid        = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        window_next  = window_reg;
        timeout_next = timeout_reg;
        act_next     = act_reg;
        hin_next     = hin_reg;
        ackn_next    = ackn_reg;
        ackok_next   = ackok_reg;
        elap_next    = elap_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        num_next     = num_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        d_next       = d_reg;
        lead_next    = lead_reg;
        n_next       = n_reg;
        hold_v_next  = hold_v_reg;
        hold_next    = hold_reg;

        if (cfg_we) begin
            if (cfg_index == rsw_pkg::REG_WINDOW) begin
                window_next = cfg_wdata[5:0];
            end else begin
                timeout_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    hin_next   = s_tdata[15:0];
                    ackn_next  = s_tdata[31:16];
                    ackok_next = s_tdata[32];
                    elap_next  = s_tdata[48:33];
                    n_next     = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                k_next    = '0;
                num_next  = base_reg;
                lead_next = 1'b1;
                r_next    = '0;
                d_next    = PW'(diff17);
                unique case (act_reg)
                    rsw_pkg::ACT_SUBMIT: begin
                        if (count_reg == DEPTH_P) begin
                            hold_v_next = 1'b1;
                            hold_next   = '{rsw_pkg::EV_FULL, 16'd0, 16'd0};
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_PASS1;
                        end
                    end
                    rsw_pkg::ACT_ACK: begin
                        if (!ack_found) begin
                            hold_v_next = 1'b1;
                            hold_next   = '{rsw_pkg::EV_UNKNOWN, 16'd0, ackn_reg};
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_PASS1;
                        end
                    end
                    rsw_pkg::ACT_TICK: state_next = S_PASS1;
                    rsw_pkg::ACT_CLEAR: begin
                        count_next = '0;
                        state_next = S_FINISH;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_PASS1, S_PASS2: begin
                if (step_en) begin
                    k_next   = k_reg + KW'(1);
                    num_next = (num_reg == SEQ_LAST) ? 16'd0 : num_reg + 16'd1;
                    if (ev_valid) begin
                        hold_v_next = 1'b1;
                        hold_next   = ev;
                        n_next      = n_reg + rsw_pkg::NCNT_W'(1);
                    end
                    if (r_inc) r_next = r_reg + PW'(1);
                    if (lead_clr) lead_next = 1'b0;
                    if (base_inc) begin
                        base_next = (base_reg == SEQ_LAST) ? 16'd0 : base_reg + 16'd1;
                    end
                    if (state_reg == S_PASS1) begin
                        if (k_reg == K_LAST) state_next = S_MID;
                    end else if (k_reg == K_LAST + KW'(r_reg)) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MID: begin
                if (act_reg == rsw_pkg::ACT_SUBMIT) count_next = count_reg + PW'(1);
                if (act_reg == rsw_pkg::ACT_ACK && ackok_reg && r_reg != '0) begin
                    count_next = count_reg - r_reg;
                    k_next     = '0;
                    num_next   = base_reg;
                    state_next = S_PASS2;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // flush the held result as the final one
                if (!hold_v_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    hold_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register: a held result moves out when a newer one arrives
    // (not last) or at the end of the command (last).
    always_comb begin
        mv_next    = mv_reg;
        mev_next   = mev_reg;
        mlast_next = mlast_reg;
        if (step_en && ev_valid && hold_v_reg) begin
            mv_next    = 1'b1;
            mev_next   = hold_reg;
            mlast_next = 1'b0;
        end else if (state_reg == S_FINISH && hold_v_reg && out_free) begin
            mv_next    = 1'b1;
            mev_next   = hold_reg;
            mlast_next = 1'b1;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            window_reg  <= rsw_pkg::WINDOW_RESET;
            timeout_reg <= rsw_pkg::TIMEOUT_RESET;
            count_reg   <= '0;
            base_reg    <= '0;
            hold_v_reg  <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            timeout_reg <= timeout_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            hold_v_reg  <= hold_v_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        hin_reg   <= hin_next;
        ackn_reg  <= ackn_next;
        ackok_reg <= ackok_next;
        elap_reg  <= elap_next;
        num_reg   <= num_next;
        k_reg     <= k_next;
        r_reg     <= r_next;
        d_reg     <= d_next;
        lead_reg  <= lead_next;
        n_reg     <= n_next;
        hold_reg  <= hold_next;
        mev_reg   <= mev_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {mev_reg.number, mev_reg.handle};
    assign m_tuser  = mev_reg.kind;
    assign m_tlast  = mlast_reg;

endmodule

FILE: hdl/rsw_checker.sv
// Port-level checks of the reliable send window, bound to the top level.
// Depends on rsw_pkg and reliable_send_window_macros.svh.
`include "reliable_send_window_macros.svh"

module rsw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    `RSW_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // one command at a time
    `RSW_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // error events carry m_tlast; they are the only result of their command
    `RSW_ASSERT_IMP(a_err_last, aclk, aresetn, m_tvalid && (m_tuser == rsw_pkg::EV_FULL || m_tuser == rsw_pkg::EV_UNKNOWN), m_tlast)
    // queue full carries no handle or number
    `RSW_ASSERT_IMP(a_full_zero, aclk, aresetn, m_tvalid && m_tuser == rsw_pkg::EV_FULL, m_tdata == 32'd0)

endmodule

bind reliable_send_window rsw_checker u_rsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
